/* rtl/skt_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted key table package
// Sizes, codes and the command and status bundles shared by the controller
// and the datapath of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int HANDLE_W = 16;
	localparam int ENTRY_W  = KEY_W + HANDLE_W;
	localparam int STATUS_W = 2;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic load;
		logic full_drop;
		logic ins_rd;
		logic ins_shift;
		logic ins_place;
		logic srch_rd;
		logic srch_hit;
		logic srch_left;
		logic srch_right;
		logic srch_miss;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic j_zero;
		logic range_empty;
		logic gt;
		logic eq;
	} dp_stat_t;

endpackage

/* rtl/skt_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module skt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/skt_dpath.sv */
// ----------------------------------------------------------------------------
// Sorted key table datapath
// Holds the command operands, the insert cursor, the search bounds, the
// record count, the record memory and the result registers.
// ----------------------------------------------------------------------------
module skt_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  skt_pkg::dp_cmd_t               cmd,
	output skt_pkg::dp_stat_t              stat,
	input  logic                           command,
	input  logic signed [skt_pkg::KEY_W-1:0] key,
	input  logic [skt_pkg::HANDLE_W-1:0]   record_handle,
	output logic [skt_pkg::STATUS_W-1:0]   status,
	output logic [skt_pkg::IDX_W-1:0]      position,
	output logic [skt_pkg::HANDLE_W-1:0]   found_handle,
	output logic [skt_pkg::CNT_W-1:0]      entry_total
);

	logic signed [skt_pkg::KEY_W-1:0] key_q;
	logic [skt_pkg::HANDLE_W-1:0]     handle_q;
	logic [skt_pkg::IDX_W-1:0]        j_q;
	logic [skt_pkg::CNT_W-1:0]        lo_q;
	logic [skt_pkg::CNT_W-1:0]        hi_q;
	logic [skt_pkg::CNT_W-1:0]        count_q;
	logic [skt_pkg::STATUS_W-1:0]     status_q;
	logic [skt_pkg::IDX_W-1:0]        position_q;
	logic [skt_pkg::HANDLE_W-1:0]     found_handle_q;
	logic [skt_pkg::CNT_W-1:0]        total_q;

	logic [skt_pkg::CNT_W-1:0]        span;
	logic [skt_pkg::CNT_W-1:0]        mid_full;
	logic [skt_pkg::IDX_W-1:0]        mid;
	logic                             we;
	logic [skt_pkg::IDX_W-1:0]        raddr;
	logic [skt_pkg::ENTRY_W-1:0]      wdata;
	logic [skt_pkg::ENTRY_W-1:0]      rdata;
	logic signed [skt_pkg::KEY_W-1:0] rd_key;
	logic [skt_pkg::HANDLE_W-1:0]     rd_handle;

	assign span     = hi_q - lo_q - skt_pkg::CNT_W'(1);
	assign mid_full = lo_q + (span >> 1);
	assign mid      = mid_full[skt_pkg::IDX_W-1:0];

	assign rd_key    = signed'(rdata[skt_pkg::ENTRY_W-1:skt_pkg::HANDLE_W]);
	assign rd_handle = rdata[skt_pkg::HANDLE_W-1:0];

	assign we    = cmd.ins_shift | cmd.ins_place;
	assign raddr = cmd.ins_rd ? (j_q - skt_pkg::IDX_W'(1)) : mid;
	assign wdata = cmd.ins_shift ? rdata : {key_q, handle_q};

	skt_ram #(
		.WIDTH(skt_pkg::ENTRY_W),
		.DEPTH(skt_pkg::CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(j_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		stat.full        = (count_q == skt_pkg::CNT_W'(skt_pkg::CAPACITY));
		stat.j_zero      = (j_q == '0);
		stat.range_empty = (lo_q >= hi_q);
		stat.gt          = (rd_key > key_q);
		stat.eq          = (rd_key == key_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins_place) begin
			count_q <= count_q + skt_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= key;
			handle_q <= (command == skt_pkg::CMD_INSERT) ? record_handle : '0;
			j_q      <= count_q[skt_pkg::IDX_W-1:0];
			lo_q     <= '0;
			hi_q     <= count_q;
		end
		if (cmd.ins_shift) begin
			j_q <= j_q - skt_pkg::IDX_W'(1);
		end
		if (cmd.srch_left) begin
			hi_q <= mid_full;
		end
		if (cmd.srch_right) begin
			lo_q <= mid_full + skt_pkg::CNT_W'(1);
		end
		if (cmd.full_drop) begin
			status_q       <= skt_pkg::ST_FULL;
			position_q     <= '0;
			found_handle_q <= '0;
			total_q        <= count_q;
		end else if (cmd.ins_place) begin
			status_q       <= skt_pkg::ST_OK;
			position_q     <= j_q;
			found_handle_q <= '0;
			total_q        <= count_q + skt_pkg::CNT_W'(1);
		end else if (cmd.srch_hit) begin
			status_q       <= skt_pkg::ST_OK;
			position_q     <= mid;
			found_handle_q <= rd_handle;
			total_q        <= count_q;
		end else if (cmd.srch_miss) begin
			status_q       <= skt_pkg::ST_NOT_FOUND;
			position_q     <= '0;
			found_handle_q <= '0;
			total_q        <= count_q;
		end
	end

	assign status       = status_q;
	assign position     = position_q;
	assign found_handle = found_handle_q;
	assign entry_total  = total_q;

endmodule

/* rtl/skt_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted key table controller
// Sequences the insertion shift loop and the binary search loop, one memory
// read in one state and one decision in the next, and raises the result strobe.
// ----------------------------------------------------------------------------
module skt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              command,
	output logic              busy,
	output logic              done,
	output skt_pkg::dp_cmd_t  cmd,
	input  skt_pkg::dp_stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_CHK,
		S_INS_CMP,
		S_SRCH_CHK,
		S_SRCH_CMP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;
	logic   done_d;
	logic   accept;

	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		done_d  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (command == skt_pkg::CMD_SEARCH) begin
						state_d = S_SRCH_CHK;
					end else if (stat.full) begin
						cmd.full_drop = 1'b1;
						done_d        = 1'b1;
					end else begin
						state_d = S_INS_CHK;
					end
				end
			end
			S_INS_CHK: begin
				if (stat.j_zero) begin
					cmd.ins_place = 1'b1;
					done_d        = 1'b1;
					state_d       = S_IDLE;
				end else begin
					cmd.ins_rd = 1'b1;
					state_d    = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (stat.gt) begin
					cmd.ins_shift = 1'b1;
					state_d       = S_INS_CHK;
				end else begin
					cmd.ins_place = 1'b1;
					done_d        = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_SRCH_CHK: begin
				if (stat.range_empty) begin
					cmd.srch_miss = 1'b1;
					done_d        = 1'b1;
					state_d       = S_IDLE;
				end else begin
					cmd.srch_rd = 1'b1;
					state_d     = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				if (stat.eq) begin
					cmd.srch_hit = 1'b1;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else if (stat.gt) begin
					cmd.srch_left = 1'b1;
					state_d       = S_SRCH_CHK;
				end else begin
					cmd.srch_right = 1'b1;
					state_d        = S_SRCH_CHK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

/* rtl/sorted_key_table_top.sv */
// ----------------------------------------------------------------------------
// Sorted key table
// A table of up to 64 records kept in ascending order of a signed key, with
// insertion-sort insert and binary search.
//
// A transaction is issued by raising start with command, key and
// record_handle while busy is low. Insert (command 0) appends the record
// and shifts larger keys up one place at a time; an equal key lands after
// the existing ones, and a full table drops the insert with status 1.
// Search (command 1) runs a binary search and returns the position and
// handle on a hit, or status 2 on a miss.
// Each transaction gives exactly one result, shown on status, position,
// found_handle and entry_total for one cycle while done is high.
// The result is registered. Each shift or probe takes a read state and then a
// compare state, because the record memory has one registered read port; a
// full-table insert skips both, and a search makes at most 7 probes. A new
// start is taken in the cycle done is high. Reset empties the table and
// clears the controller. The receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_key_table_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             command,
	input  logic signed [skt_pkg::KEY_W-1:0] key,
	input  logic [skt_pkg::HANDLE_W-1:0]     record_handle,
	output logic                             done,
	output logic [skt_pkg::STATUS_W-1:0]     status,
	output logic [skt_pkg::IDX_W-1:0]        position,
	output logic [skt_pkg::HANDLE_W-1:0]     found_handle,
	output logic [skt_pkg::CNT_W-1:0]        entry_total
);

	skt_pkg::dp_cmd_t  cmd;
	skt_pkg::dp_stat_t stat;

	skt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(command),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	skt_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.command      (command),
		.key          (key),
		.record_handle(record_handle),
		.status       (status),
		.position     (position),
		.found_handle (found_handle),
		.entry_total  (entry_total)
	);

endmodule

/* tb/sorted_key_table_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table testbench
// Issues insert and search transactions with random gaps and checks each
// result against a scoreboard that keeps its own sorted copy of the table.
// The scoreboard inserts records as insertion sort does and probes them with
// the same binary search, so duplicate keys resolve to the same record.
// ----------------------------------------------------------------------------
module sorted_key_table_top_tb;
	import skt_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 1930;
	localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
	localparam int MAX_REPORTS  = 100;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    position;
		logic [HANDLE_W-1:0] found_handle;
		logic [CNT_W-1:0]    entry_total;
	} table_answer_t;

	class key_table_scoreboard;
		logic signed [KEY_W-1:0] key_table [CAPACITY];
		logic [HANDLE_W-1:0]     handle_table [CAPACITY];
		int unsigned             record_count;
		table_answer_t           pending_answers [$];
		int                      mismatch_count;

		function new();
			record_count   = 0;
			mismatch_count = 0;
		endfunction

		task report(string what);
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS) begin
				$display("mismatch at %0t: %s", $realtime, what);
			end
		endtask

		function void note_command(logic cmd, logic signed [KEY_W-1:0] k,
			logic [HANDLE_W-1:0] h);
			table_answer_t answer;
			int            slot;
			int            lo;
			int            hi;
			int            mid;
			bit            hit;
			answer = '0;
			if (cmd == CMD_INSERT) begin
				if (record_count >= CAPACITY) begin
					answer.status = ST_FULL;
				end else begin
					slot = record_count;
					while (slot > 0 && key_table[slot-1] > k) begin
						key_table[slot]    = key_table[slot-1];
						handle_table[slot] = handle_table[slot-1];
						slot--;
					end
					key_table[slot]    = k;
					handle_table[slot] = h;
					record_count++;
					answer.status   = ST_OK;
					answer.position = slot[IDX_W-1:0];
				end
			end else begin
				answer.status = ST_NOT_FOUND;
				hit = 1'b0;
				lo  = 0;
				hi  = int'(record_count) - 1;
				while (!hit && hi >= lo) begin
					mid = lo + (hi - lo) / 2;
					if (key_table[mid] == k) begin
						hit                 = 1'b1;
						answer.status       = ST_OK;
						answer.position     = mid[IDX_W-1:0];
						answer.found_handle = handle_table[mid];
					end else if (key_table[mid] > k) begin
						hi = mid - 1;
					end else begin
						lo = mid + 1;
					end
				end
			end
			answer.entry_total = record_count[CNT_W-1:0];
			pending_answers.push_back(answer);
		endfunction

		task check_result(logic [STATUS_W-1:0] st, logic [IDX_W-1:0] pos,
			logic [HANDLE_W-1:0] fh, logic [CNT_W-1:0] tot);
			table_answer_t want;
			if (pending_answers.size() == 0) begin
				report("result with no transaction outstanding");
				return;
			end
			want = pending_answers.pop_front();
			if (st !== want.status) begin
				report($sformatf("status %0d, expected %0d", st, want.status));
			end
			if (pos !== want.position) begin
				report($sformatf("position %0d, expected %0d", pos, want.position));
			end
			if (fh !== want.found_handle) begin
				report($sformatf("found_handle %h, expected %h", fh, want.found_handle));
			end
			if (tot !== want.entry_total) begin
				report($sformatf("entry_total %0d, expected %0d", tot, want.entry_total));
			end
		endtask
	endclass

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    start         = 1'b0;
	logic                    command       = CMD_INSERT;
	logic signed [KEY_W-1:0] key           = '0;
	logic [HANDLE_W-1:0]     record_handle = '0;
	logic                    busy;
	logic                    done;
	logic [STATUS_W-1:0]     status;
	logic [IDX_W-1:0]        position;
	logic [HANDLE_W-1:0]     found_handle;
	logic [CNT_W-1:0]        entry_total;

	key_table_scoreboard scoreboard = new();
	int                  cycle_count = 0;
	bit                  allow_gaps  = 1'b1;

	sorted_key_table_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.key          (key),
		.record_handle(record_handle),
		.done         (done),
		.status       (status),
		.position     (position),
		.found_handle (found_handle),
		.entry_total  (entry_total)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			scoreboard.check_result(status, position, found_handle, entry_total);
		end
		if (arst_n && start && !busy) begin
			scoreboard.note_command(command, key, record_handle);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic issue_command(input logic cmd, input logic signed [KEY_W-1:0] k,
		input logic [HANDLE_W-1:0] h);
		int gap;
		gap = allow_gaps ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		command       <= cmd;
		key           <= k;
		record_handle <= h;
		do @(posedge clk); while (busy);
	endtask

	function automatic logic signed [KEY_W-1:0] pick_key(bit for_search);
		int unsigned             sel;
		logic signed [KEY_W-1:0] stored;
		sel = $urandom_range(0, 99);
		if (for_search && scoreboard.record_count > 0 && sel < 55) begin
			stored = scoreboard.key_table[$urandom_range(0, scoreboard.record_count - 1)];
			if (sel < 45) begin
				return stored;
			end
			return (sel < 50) ? stored + 1 : stored - 1;
		end
		if (sel < 75) begin
			return int'($urandom_range(0, 16)) - 8;
		end
		if (sel < 85) begin
			case ($urandom_range(0, 3))
				0: return 32'sh8000_0000;
				1: return 32'sh7FFF_FFFF;
				2: return 32'sh8000_0001;
				default: return 32'sh7FFF_FFFE;
			endcase
		end
		return $urandom;
	endfunction

	initial begin
		logic cmd;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue_command(CMD_SEARCH, 0, 16'h1234);
		issue_command(CMD_INSERT, 0, 16'h0000);
		issue_command(CMD_INSERT, 32'sh7FFF_FFFF, 16'hFFFF);
		issue_command(CMD_INSERT, 32'sh8000_0000, 16'h0001);
		issue_command(CMD_INSERT, -1, 16'h8000);
		issue_command(CMD_INSERT, 0, 16'hFFFF);
		issue_command(CMD_INSERT, 0, 16'h00FF);
		issue_command(CMD_INSERT, 32'sh8000_0000, 16'h0002);
		issue_command(CMD_SEARCH, 0, 16'hFFFF);
		issue_command(CMD_SEARCH, 32'sh8000_0000, 16'h0000);
		issue_command(CMD_SEARCH, 32'sh7FFF_FFFF, 16'h5A5A);
		issue_command(CMD_SEARCH, -1, 16'h0000);
		issue_command(CMD_SEARCH, 1, 16'h0000);
		issue_command(CMD_SEARCH, 32'sh7FFF_FFFE, 16'h0000);
		issue_command(CMD_SEARCH, 32'sh8000_0001, 16'h0000);
		issue_command(CMD_INSERT, 1, 16'hA5A5);
		issue_command(CMD_INSERT, 32'sh4000_0000, 16'h7FFF);
		issue_command(CMD_INSERT, -32'sh4000_0000, 16'h1357);
		issue_command(CMD_SEARCH, 32'sh4000_0000, 16'h0000);
		issue_command(CMD_SEARCH, -32'sh4000_0000, 16'h0000);

		// Inserts are kept rare so the table fills gradually and then stays full.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0) begin
				allow_gaps = ($urandom_range(0, 3) != 0);
			end
			cmd = ($urandom_range(0, 99) < 15) ? CMD_INSERT : CMD_SEARCH;
			issue_command(cmd, pick_key(cmd == CMD_SEARCH), 16'($urandom));
		end
		start <= 1'b0;

		while (scoreboard.pending_answers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (scoreboard.pending_answers.size() != 0) begin
			scoreboard.report($sformatf("%0d transactions never answered",
				scoreboard.pending_answers.size()));
		end
		if (scoreboard.mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* sorted_key_table_top.f */
rtl/skt_pkg.sv
rtl/skt_ram.sv
rtl/skt_dpath.sv
rtl/skt_ctrl.sv
rtl/sorted_key_table_top.sv
tb/sorted_key_table_top_tb.sv
